[src/mrpw_pkg.sv]
// ----------------------------------------------------------------------------
// Masked region pixel writer package
// Payload layouts, register indexes and pixel format codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrpw_pkg;

   localparam int REQ_DATA_W  = 72;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int COORD_W     = 12;
   localparam int OFFSET_W    = 24;
   localparam int PIXEL_W     = 32;

   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_PIXEL_FORMAT  = 2'd2;

   localparam logic [1:0] FMT_8BPP        = 2'd0;
   localparam logic [1:0] FMT_16BPP       = 2'd1;
   localparam logic [1:0] FMT_32BPP       = 2'd2;
   localparam logic [1:0] FMT_UNSUPPORTED = 2'd3;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd800;
   localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic [3:0]  pad;
      logic [31:0] color;
      logic [11:0] region_width;
      logic [11:0] origin_y;
      logic [11:0] origin_x;
   } req_data_type;

   typedef struct packed {
      logic       mask_on;
      logic       region_start;
   } req_user_type;

   typedef struct packed {
      logic [5:0]  pad;
      logic [1:0]  write_size;
      logic [31:0] write_data;
      logic [23:0] byte_offset;
   } rsp_data_type;

endpackage

`default_nettype wire

[src/masked_region_pixel_writer_top.sv]
// ----------------------------------------------------------------------------
// Masked region pixel writer
// Walks a mask region in row-major order and emits clipped framebuffer writes.
// ----------------------------------------------------------------------------
// A request's write passes through the position register and then the result
// register; requests that draw nothing leave no result.
// Throughput: one request per cycle while the result side does not stall; the
// offset multiply is combinational between the two registers.
// Reset is synchronous: counters and origin clear, the width becomes one and
// the registers return to 800 x 480 at 16 bpp.
`timescale 1ns / 1ps
`default_nettype none

module masked_region_pixel_writer_top #(
   parameter int MAX_DIM = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: origin_x, origin_y, region_width, color, zero padding.
   input  wire logic [71:0] req_tdata,
   // req_tuser: region_start, mask_on.
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: byte_offset, write_data, write_size, zero padding.
   output logic [63:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CW   = $clog2(MAX_DIM);
   localparam int WW   = CW + 1;
   localparam int CMPW = (WW > 12) ? WW : 12;
   localparam int PW   = ((CW > 12) ? CW : 12) + 2;

   mrpw_pkg::req_data_type req_data;
   mrpw_pkg::req_user_type req_user;
   mrpw_pkg::rsp_data_type rsp_data_in;

   logic [11:0]          screen_width_ff;
   logic [11:0]          screen_height_ff;
   logic [1:0]           pixel_format_ff;

   logic [CW-1:0]        column_count_ff, column_count_in;
   logic [CW-1:0]        row_count_ff, row_count_in;
   logic [11:0]          held_origin_x_ff, held_origin_x_in;
   logic [11:0]          held_origin_y_ff, held_origin_y_in;
   logic [WW-1:0]        held_width_ff, held_width_in;

   logic                 pos_valid_ff;
   logic signed [PW-1:0] pos_x_ff, pos_x_in;
   logic signed [PW-1:0] pos_y_ff, pos_y_in;
   logic [31:0]          pos_color_ff;
   logic                 pos_mask_ff;

   logic                 rsp_valid_ff;
   logic [63:0]          rsp_data_ff;

   logic                 req_accept;
   logic                 out_free;
   logic                 csr_write;
   logic [11:0]          width_nz;
   logic [CMPW-1:0]      width_wide;
   logic [CW-1:0]        col_base, row_base;
   logic [WW-1:0]        col_next, row_next;
   logic                 visible;
   logic                 emit;
   logic [23:0]          linear_pos;
   logic [23:0]          offset;
   logic [31:0]          pixel_data;
   logic [1:0]           pixel_size;

   assign req_data = mrpw_pkg::req_data_type'(req_tdata);
   assign req_user = mrpw_pkg::req_user_type'(req_tuser);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !pos_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[3:2])
         mrpw_pkg::REG_SCREEN_WIDTH:  csr_prdata = {20'd0, screen_width_ff};
         mrpw_pkg::REG_SCREEN_HEIGHT: csr_prdata = {20'd0, screen_height_ff};
         mrpw_pkg::REG_PIXEL_FORMAT:  csr_prdata = {30'd0, pixel_format_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= mrpw_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= mrpw_pkg::SCREEN_HEIGHT_RESET;
         pixel_format_ff  <= mrpw_pkg::FMT_16BPP;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            mrpw_pkg::REG_SCREEN_WIDTH:  screen_width_ff  <= csr_pwdata[11:0];
            mrpw_pkg::REG_SCREEN_HEIGHT: screen_height_ff <= csr_pwdata[11:0];
            mrpw_pkg::REG_PIXEL_FORMAT:  pixel_format_ff  <= csr_pwdata[1:0];
            default: begin
            end
         endcase
      end
   end

   // A region start takes the new origin and width and restarts at (0,0).
   always_comb begin
      width_nz   = (req_data.region_width == 12'd0) ? 12'd1 : req_data.region_width;
      width_wide = CMPW'(width_nz);

      held_origin_x_in = held_origin_x_ff;
      held_origin_y_in = held_origin_y_ff;
      held_width_in    = held_width_ff;
      col_base         = column_count_ff;
      row_base         = row_count_ff;
      if (req_user.region_start) begin
         held_origin_x_in = req_data.origin_x;
         held_origin_y_in = req_data.origin_y;
         if (width_wide > CMPW'(MAX_DIM)) begin
            held_width_in = WW'(MAX_DIM);
         end else begin
            held_width_in = WW'(width_wide);
         end
         col_base = '0;
         row_base = '0;
      end

      pos_x_in = $signed({{(PW-12){held_origin_x_in[11]}}, held_origin_x_in})
               + $signed({{(PW-CW){1'b0}}, col_base});
      pos_y_in = $signed({{(PW-12){held_origin_y_in[11]}}, held_origin_y_in})
               + $signed({{(PW-CW){1'b0}}, row_base});

      col_next = {1'b0, col_base} + WW'(1);
      row_next = {1'b0, row_base} + WW'(1);
      if (col_next >= held_width_in) begin
         column_count_in = '0;
         if (row_next >= WW'(MAX_DIM)) begin
            row_count_in = '0;
         end else begin
            row_count_in = row_next[CW-1:0];
         end
      end else begin
         column_count_in = col_next[CW-1:0];
         row_count_in    = row_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff  <= '0;
         row_count_ff     <= '0;
         held_origin_x_ff <= '0;
         held_origin_y_ff <= '0;
         held_width_ff    <= WW'(1);
      end else if (req_accept) begin
         column_count_ff  <= column_count_in;
         row_count_ff     <= row_count_in;
         held_origin_x_ff <= held_origin_x_in;
         held_origin_y_ff <= held_origin_y_in;
         held_width_ff    <= held_width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff <= 1'b0;
      end else if (req_tready) begin
         pos_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_color_ff <= req_data.color;
         pos_mask_ff  <= req_user.mask_on;
      end
   end

   assign visible = !pos_x_ff[PW-1] && !pos_y_ff[PW-1]
                 && (pos_x_ff < $signed({{(PW-12){1'b0}}, screen_width_ff}))
                 && (pos_y_ff < $signed({{(PW-12){1'b0}}, screen_height_ff}));

   // On screen both coordinates fit in twelve bits.
   assign linear_pos = 24'(pos_y_ff[11:0]) * 24'(screen_width_ff) + 24'(pos_x_ff[11:0]);

   always_comb begin
      unique case (pixel_format_ff)
         mrpw_pkg::FMT_8BPP: begin
            pixel_data = {24'd0, pos_color_ff[7:0]};
            pixel_size = mrpw_pkg::SIZE_BYTE;
            offset     = linear_pos;
            emit       = pos_mask_ff && visible;
         end
         mrpw_pkg::FMT_16BPP: begin
            pixel_data = {16'd0, pos_color_ff[23:19], pos_color_ff[15:10],
                          pos_color_ff[7:3]};
            pixel_size = mrpw_pkg::SIZE_HALF;
            offset     = {linear_pos[22:0], 1'b0};
            emit       = pos_mask_ff && visible;
         end
         mrpw_pkg::FMT_32BPP: begin
            pixel_data = pos_color_ff;
            pixel_size = mrpw_pkg::SIZE_WORD;
            offset     = {linear_pos[21:0], 2'b00};
            emit       = pos_mask_ff && visible;
         end
         default: begin
            pixel_data = pos_color_ff;
            pixel_size = mrpw_pkg::SIZE_WORD;
            offset     = linear_pos;
            emit       = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in             = '0;
      rsp_data_in.byte_offset = offset;
      rsp_data_in.write_data  = pixel_data;
      rsp_data_in.write_size  = pixel_size;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= pos_valid_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && pos_valid_ff && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Masked region pixel writer testbench
// Streams mask regions into the writer under several screen settings and pixel
// formats, predicts every framebuffer write in step with the accepted requests,
// and compares each write field by field while both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_DIM         = 2048;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 1000000;

   logic                            clock;
   logic                            reset;
   logic [mrpw_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [mrpw_pkg::REQ_USER_W-1:0] req_tuser;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [mrpw_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [mrpw_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [mrpw_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [mrpw_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   masked_region_pixel_writer_top #(
      .MAX_DIM(MAX_DIM)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Mirror of the screen registers and of the region walk.
   int          scr_width;
   int          scr_height;
   logic [1:0]  pix_format;
   int          walk_column;
   int          walk_row;
   int          base_x;
   int          base_y;
   int          span;

   mrpw_pkg::rsp_data_type expected_writes[$];
   int          mismatch_count;
   int          sent_count;
   int          cycle_count;
   bit          steady;
   bit          hold_off_pending;

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic bit predict_pixel_write(input mrpw_pkg::req_user_type u,
                                              input mrpw_pkg::req_data_type d,
                                              output mrpw_pkg::rsp_data_type w);
      int     x;
      int     y;
      int     w_in;
      longint bytes;
      longint offset;
      w = '0;
      if (u.region_start) begin
         w_in = d.region_width;
         if (w_in == 0)
            w_in = 1;
         if (w_in > MAX_DIM)
            w_in = MAX_DIM;
         base_x = $signed(d.origin_x);
         base_y = $signed(d.origin_y);
         span = w_in;
         walk_column = 0;
         walk_row = 0;
      end
      x = base_x + walk_column;
      y = base_y + walk_row;
      walk_column++;
      if (walk_column >= span) begin
         walk_column = 0;
         walk_row++;
         if (walk_row >= MAX_DIM)
            walk_row = 0;
      end
      if (!u.mask_on || pix_format > mrpw_pkg::FMT_32BPP)
         return 0;
      if (x < 0 || y < 0 || x >= scr_width || y >= scr_height)
         return 0;
      case (pix_format)
         mrpw_pkg::FMT_8BPP: begin
            bytes = 1;
            w.write_size = mrpw_pkg::SIZE_BYTE;
            w.write_data = {24'h0, d.color[7:0]};
         end
         mrpw_pkg::FMT_16BPP: begin
            bytes = 2;
            w.write_size = mrpw_pkg::SIZE_HALF;
            w.write_data = {16'h0, d.color[23:19], d.color[15:10], d.color[7:3]};
         end
         default: begin
            bytes = 4;
            w.write_size = mrpw_pkg::SIZE_WORD;
            w.write_data = d.color;
         end
      endcase
      offset = longint'(y) * longint'(scr_width) * bytes + longint'(x) * bytes;
      w.byte_offset = offset[23:0];
      return 1;
   endfunction

   always @(posedge clock) begin : check_writes
      mrpw_pkg::rsp_data_type got;
      mrpw_pkg::rsp_data_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_writes.size() == 0) begin
            note_mismatch("unexpected write", 64'h0, got);
         end else begin
            want = expected_writes.pop_front();
            if (got.byte_offset !== want.byte_offset)
               note_mismatch("byte_offset", want.byte_offset, got.byte_offset);
            if (got.write_data !== want.write_data)
               note_mismatch("write_data", want.write_data, got.write_data);
            if (got.write_size !== want.write_size)
               note_mismatch("write_size", want.write_size, got.write_size);
         end
      end
   end

   // Result side: random stalls, plus one long hold-off when a test asks for it.
   initial begin : drive_result_ready
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_pending = 1'b0;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 15)
               stall_left = pick_gap();
         end
      end
   end

   task automatic send_request(input bit start, input logic [11:0] ox, input logic [11:0] oy,
                               input logic [11:0] width, input logic [31:0] color,
                               input bit mask);
      mrpw_pkg::req_data_type d;
      mrpw_pkg::req_user_type u;
      mrpw_pkg::rsp_data_type w;
      int                     gap;
      d = '0;
      d.origin_x = ox;
      d.origin_y = oy;
      d.region_width = width;
      d.color = color;
      u.region_start = start;
      u.mask_on = mask;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tdata <= d;
      req_tuser <= u;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      if (predict_pixel_write(u, d, w))
         expected_writes.push_back(w);
   endtask

   task automatic drain_writes();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [11:0] value);
      logic [31:0] want;
      want = (index == mrpw_pkg::REG_PIXEL_FORMAT) ? {30'h0, value[1:0]} : {20'h0, value};
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {20'h0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         mrpw_pkg::REG_SCREEN_WIDTH:  scr_width = value;
         mrpw_pkg::REG_SCREEN_HEIGHT: scr_height = value;
         default:                     pix_format = value[1:0];
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want)
         note_mismatch("register read", want, csr_prdata);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_screen(input logic [11:0] width, input logic [11:0] height,
                             input logic [1:0] format);
      drain_writes();
      write_register(mrpw_pkg::REG_SCREEN_WIDTH, width);
      write_register(mrpw_pkg::REG_SCREEN_HEIGHT, height);
      write_register(mrpw_pkg::REG_PIXEL_FORMAT, {10'h0, format});
   endtask

   task automatic test_default_screen();
      send_request(1, 12'd0, 12'd0, 12'd0, 32'h00FF_FFFF, 1);
      send_request(0, 12'hFFF, 12'hFFF, 12'hFFF, 32'h0000_0000, 1);
      send_request(1, 12'd799, 12'd479, 12'd2, 32'h00F8_0408, 1);
      send_request(0, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 1);
      send_request(0, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 1);
      send_request(1, 12'hFFF, 12'hFFF, 12'hFFF, 32'h0012_3456, 1);
      send_request(0, 12'd0, 12'd0, 12'd0, 32'h0012_3456, 1);
      send_request(1, 12'h800, 12'h7FF, 12'd1, 32'h0055_AA55, 1);
      send_request(1, 12'h7FF, 12'h800, 12'd1, 32'h00AA_55AA, 1);
      send_request(1, 12'd10, 12'd10, 12'd3, 32'h0080_8080, 0);
      send_request(0, 12'd0, 12'd0, 12'd0, 32'h0080_8080, 1);
   endtask

   task automatic test_pixel_formats();
      for (int f = 0; f < 4; f++) begin
         set_screen(12'd320, 12'd240, f[1:0]);
         send_request(1, 12'd5, 12'd3, 12'd1, 32'hA5C3_5A7E, 1);
         send_request(0, 12'd0, 12'd0, 12'd0, 32'h5A3C_A581, 1);
      end
   endtask

   task automatic test_screen_extremes();
      set_screen(12'hFFF, 12'hFFF, mrpw_pkg::FMT_32BPP);
      send_request(1, 12'h7FF, 12'h7FF, 12'd1, 32'hDEAD_BEEF, 1);
      send_request(0, 12'd0, 12'd0, 12'd0, 32'h0BAD_F00D, 1);
      set_screen(12'd0, 12'd480, mrpw_pkg::FMT_16BPP);
      send_request(1, 12'd0, 12'd0, 12'd1, 32'h00FF_FFFF, 1);
      set_screen(12'd800, 12'd0, mrpw_pkg::FMT_8BPP);
      send_request(1, 12'd0, 12'd0, 12'd1, 32'h00FF_FFFF, 1);
   endtask

   // A one-column region that starts above the screen and runs down into it.
   task automatic test_long_column();
      set_screen(12'd64, 12'd480, mrpw_pkg::FMT_16BPP);
      send_request(1, 12'd3, 12'($signed(-200)), 12'd1, $urandom, 1);
      for (int i = 0; i < 300; i++)
         send_request(0, 12'($urandom), 12'($urandom), 12'($urandom), $urandom, 1);
   endtask

   function automatic logic [11:0] pick_origin(input int extent);
      if ($urandom_range(0, 9) < 8)
         return 12'(int'($urandom_range(0, extent + 16)) - 8);
      return 12'($urandom);
   endfunction

   function automatic logic [11:0] pick_width();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 12'($urandom_range(1, 16));
      if (roll < 92)
         return 12'($urandom_range(1, 200));
      return 12'($urandom);
   endfunction

   task automatic send_random_region();
      logic [11:0] width;
      int          total;
      int          mask_odds;
      width = pick_width();
      total = (width == 0 ? 1 : width) * $urandom_range(1, 4);
      if (total > 48)
         total = $urandom_range(1, 48);
      if ($urandom_range(0, 99) < 15)
         total = $urandom_range(1, total);
      mask_odds = ($urandom_range(0, 4) == 0) ? 100 : 75;
      send_request(1, pick_origin(scr_width), pick_origin(scr_height), width, $urandom,
                   $urandom_range(0, 99) < mask_odds);
      for (int i = 1; i < total; i++)
         send_request(0, 12'($urandom), 12'($urandom), 12'($urandom), $urandom,
                      $urandom_range(0, 99) < mask_odds);
   endtask

   task automatic test_random_regions();
      logic [11:0] widths[8];
      logic [11:0] heights[8];
      logic [1:0]  formats[8];
      int          first;
      widths  = '{12'd800, 12'd1, 12'd2047, 12'hFFF, 12'd0, 12'd64, 12'd333, 12'd0};
      heights = '{12'd480, 12'd1, 12'd2047, 12'hFFF, 12'd100, 12'd0, 12'd48, 12'd0};
      formats = '{mrpw_pkg::FMT_16BPP, mrpw_pkg::FMT_8BPP, mrpw_pkg::FMT_32BPP,
                  mrpw_pkg::FMT_32BPP, mrpw_pkg::FMT_16BPP, mrpw_pkg::FMT_32BPP,
                  mrpw_pkg::FMT_UNSUPPORTED, mrpw_pkg::FMT_8BPP};
      widths[7] = 12'($urandom_range(1, 2048));
      heights[7] = 12'($urandom_range(1, 2048));
      formats[7] = 2'($urandom_range(0, 2));
      for (int p = 0; p < 8; p++) begin
         set_screen(widths[p], heights[p], formats[p]);
         steady = (p % 3 == 2);
         first = sent_count;
         while (sent_count - first < 100) begin
            if ($urandom_range(0, 9) == 0)
               send_request($urandom_range(0, 1), 12'($urandom), 12'($urandom),
                            12'($urandom), $urandom, $urandom_range(0, 1));
            else
               send_random_region();
         end
         steady = 1'b0;
      end
   endtask

   // The result side holds off for a long stretch so the block fills and
   // stops taking requests.
   task automatic test_backpressure();
      set_screen(12'd64, 12'd48, mrpw_pkg::FMT_32BPP);
      hold_off_pending = 1'b1;
      steady = 1'b1;
      send_request(1, 12'd0, 12'd0, 12'd16, $urandom, 1);
      for (int i = 1; i < 120; i++)
         send_request(0, 12'($urandom), 12'($urandom), 12'($urandom), $urandom, 1);
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_tdata = '0;
      req_tuser = '0;
      req_tvalid = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycle_count = 0;
      mismatch_count = 0;
      sent_count = 0;
      steady = 1'b0;
      hold_off_pending = 1'b0;
      scr_width = mrpw_pkg::SCREEN_WIDTH_RESET;
      scr_height = mrpw_pkg::SCREEN_HEIGHT_RESET;
      pix_format = mrpw_pkg::FMT_16BPP;
      walk_column = 0;
      walk_row = 0;
      base_x = 0;
      base_y = 0;
      span = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_screen();
      test_pixel_formats();
      test_screen_extremes();
      test_long_column();
      test_random_regions();
      test_backpressure();
      drain_writes();

      if (mismatch_count == 0 && expected_writes.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
